>>> sv/pdr_pkg.sv
package pdr_pkg;

	localparam int DISPLAY_SIZE_DEF = 128;
	localparam int QUEUE_DEPTH_DEF  = 4;

	localparam int SRC_W   = 12;
	localparam int PIXEL_W = 16;
	localparam int DEST_W  = 7;
	localparam int OVL_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [1:0] {
		OP_FRAME = 2'd0,
		OP_LINE  = 2'd1,
		OP_PIXEL = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROTATION    = 2'd0,
		REG_SOURCE_SIZE = 2'd1,
		REG_OVERLAY_ROW = 2'd2
	} reg_idx_t;

	// settings the output side needs
	typedef struct packed {
		rot_t             rotation;
		logic [OVL_W-1:0] overlay_start_row;
	} back_cfg_t;

	localparam rot_t             ROTATION_RST    = ROT_0;
	localparam logic [SRC_W-1:0] SOURCE_SIZE_RST = 12'd480;
	localparam logic [OVL_W-1:0] OVERLAY_ROW_RST = 8'd96;

endpackage

>>> sv/pdr_front.sv
module pdr_front #(
	parameter int DISPLAY_SIZE = pdr_pkg::DISPLAY_SIZE_DEF,
	parameter int CW = $clog2(DISPLAY_SIZE),
	parameter int ENTRY_W = 2 * CW + pdr_pkg::PIXEL_W + 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [1:0]                  operation,
	input  logic [pdr_pkg::PIXEL_W-1:0] pixel,
	input  logic                        overlay_active,
	input  logic [pdr_pkg::SRC_W-1:0]   source_size,
	input  logic                        push_ready,
	output logic                        push,
	output logic [ENTRY_W-1:0]          push_data
);

	localparam int RW = $clog2(DISPLAY_SIZE + 1);
	localparam int SW = pdr_pkg::SRC_W;

	logic          first_pending_q;
	logic          line_kept_q;
	logic [SW-1:0] line_acc_q;
	logic [SW-1:0] col_acc_q;
	logic [RW-1:0] row_q;
	logic [RW-1:0] col_q;

	logic          accept;
	logic          is_line;
	logic [SW-1:0] acc_in;
	logic [SW:0]   acc_sum;
	logic [SW:0]   acc_wrapped;
	logic          acc_wrap;
	logic [SW-1:0] acc_next;
	logic          pixel_live;
	logic [RW-1:0] row_inc;

	assign accept  = in_valid && push_ready;
	assign is_line = (operation == pdr_pkg::OP_LINE);

	// one shared step unit: only one accumulator moves per item
	assign acc_in      = is_line ? line_acc_q : col_acc_q;
	assign acc_sum     = {1'b0, acc_in} + (SW+1)'(DISPLAY_SIZE);
	assign acc_wrap    = acc_sum >= {1'b0, source_size};
	assign acc_wrapped = acc_sum - {1'b0, source_size};
	assign acc_next    = acc_wrap ? acc_wrapped[SW-1:0] : acc_sum[SW-1:0];

	assign pixel_live = (operation == pdr_pkg::OP_PIXEL) && line_kept_q &&
		(col_q < RW'(DISPLAY_SIZE));
	assign row_inc = (row_q < RW'(DISPLAY_SIZE)) ? row_q + RW'(1) : row_q;

	assign push      = accept && pixel_live && acc_wrap;
	assign push_data = {overlay_active, pixel, row_q[CW-1:0], col_q[CW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pending_q <= 1'b1;
			line_kept_q     <= 1'b0;
			line_acc_q      <= '0;
			col_acc_q       <= '0;
			row_q           <= '0;
			col_q           <= '0;
		end else if (accept) begin
			case (pdr_pkg::op_t'(operation))
				pdr_pkg::OP_FRAME: begin
					first_pending_q <= 1'b1;
					line_kept_q     <= 1'b0;
					line_acc_q      <= '0;
					col_acc_q       <= '0;
					row_q           <= '0;
					col_q           <= '0;
				end
				pdr_pkg::OP_LINE: begin
					col_acc_q <= '0;
					col_q     <= '0;
					if (first_pending_q) begin
						first_pending_q <= 1'b0;
						line_acc_q      <= '0;
						row_q           <= '0;
						line_kept_q     <= 1'b1;
					end else begin
						line_acc_q <= acc_next;
						if (acc_wrap) begin
							row_q       <= row_inc;
							line_kept_q <= row_inc < RW'(DISPLAY_SIZE);
						end else begin
							line_kept_q <= 1'b0;
						end
					end
				end
				pdr_pkg::OP_PIXEL: begin
					if (pixel_live) begin
						col_acc_q <= acc_next;
						if (acc_wrap)
							col_q <= col_q + RW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= RW'(DISPLAY_SIZE))
		else $error("display row beyond display size");

	a_push_kept_line: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> line_kept_q && !first_pending_q)
		else $error("pixel queued from a line that is not kept");

endmodule

>>> sv/pdr_queue.sv
module pdr_queue #(
	parameter int DEPTH = pdr_pkg::QUEUE_DEPTH_DEF,
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	output logic         pop_valid,
	input  logic         pop,
	output logic [W-1:0] pop_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full      = (count_q == NW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + NW'(1);
			else if (pop && !push)
				count_q <= count_q - NW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("pop from an empty queue");

endmodule

>>> sv/pdr_back.sv
module pdr_back #(
	parameter int DISPLAY_SIZE = pdr_pkg::DISPLAY_SIZE_DEF,
	parameter int CW = $clog2(DISPLAY_SIZE),
	parameter int ENTRY_W = 2 * CW + pdr_pkg::PIXEL_W + 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pdr_pkg::back_cfg_t          cfg,
	input  logic                        entry_valid,
	input  logic [ENTRY_W-1:0]          entry,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [pdr_pkg::DEST_W-1:0]  dest_x,
	output logic [pdr_pkg::DEST_W-1:0]  dest_y,
	output logic [pdr_pkg::PIXEL_W-1:0] color
);

	localparam int OW = pdr_pkg::OVL_W + 2;
	localparam logic [CW-1:0] M = CW'(DISPLAY_SIZE - 1);

	logic [CW-1:0]               x;
	logic [CW-1:0]               y;
	logic [pdr_pkg::PIXEL_W-1:0] pix;
	logic                        ovl;
	logic [CW-1:0]               dx;
	logic [CW-1:0]               dy;
	logic                        suppress;

	logic                        out_valid_q;
	logic [pdr_pkg::DEST_W-1:0]  dest_x_q;
	logic [pdr_pkg::DEST_W-1:0]  dest_y_q;
	logic [pdr_pkg::PIXEL_W-1:0] color_q;

	assign {ovl, pix, y, x} = entry;

	always_comb begin
		case (cfg.rotation)
			pdr_pkg::ROT_90: begin
				dx = M - y;
				dy = x;
			end
			pdr_pkg::ROT_180: begin
				dx = M - x;
				dy = M - y;
			end
			pdr_pkg::ROT_270: begin
				dx = y;
				dy = M - x;
			end
			default: begin
				dx = x;
				dy = y;
			end
		endcase
	end

	assign suppress = ovl && (OW'(dy) >= OW'(cfg.overlay_start_row));
	assign pop      = entry_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= !suppress;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop && !suppress) begin
			dest_x_q <= pdr_pkg::DEST_W'(dx);
			dest_y_q <= pdr_pkg::DEST_W'(dy);
			color_q  <= {pix[7:0], pix[15:8]};
		end
	end

	assign out_valid = out_valid_q;
	assign dest_x    = dest_x_q;
	assign dest_y    = dest_y_q;
	assign color     = color_q;

endmodule

>>> sv/pixel_downscale_rotate_writer.sv
// Nearest-neighbour downscaler for a square camera stream: frame-start, line-start and pixel
// items come in, and each kept pixel leaves as a display write (dest_x, dest_y, color) with its
// bytes swapped and its coordinate rotated by 0, 90, 180 or 270 degrees. One item is taken every
// clock cycle while the queue has room; the line and column accumulators share one
// add-and-compare step unit, so every item finishes its front-end work in the cycle it is
// accepted. A write passes through the queue and then the output register before it is valid
// on the output. A short queue sits between the accumulator front end and the rotate/output
// stage, so in_ready only drops once the queue is full because the display side has held out_ready
// low. Writes into the overlay rows are dropped in the output stage while overlay_active was set
// on their pixel. Registers (rotation, source_size, overlay_start_row) are written through the
// cfg port, which is always ready, and should only change while idle.
module pixel_downscale_rotate_writer #(
	parameter int DISPLAY_SIZE = pdr_pkg::DISPLAY_SIZE_DEF,
	parameter int QUEUE_DEPTH  = pdr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,

	// camera side
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     operation,
	input  logic [pdr_pkg::PIXEL_W-1:0]    pixel,
	input  logic                           overlay_active,

	// display write side
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pdr_pkg::DEST_W-1:0]     dest_x,
	output logic [pdr_pkg::DEST_W-1:0]     dest_y,
	output logic [pdr_pkg::PIXEL_W-1:0]    color,

	// register writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pdr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW      = $clog2(DISPLAY_SIZE);
	localparam int ENTRY_W = 2 * CW + pdr_pkg::PIXEL_W + 1;

	// configuration registers
	pdr_pkg::rot_t                rotation_q;
	logic [pdr_pkg::SRC_W-1:0]    source_size_q;
	logic [pdr_pkg::OVL_W-1:0]    overlay_row_q;
	pdr_pkg::back_cfg_t           back_cfg;

	// queue between front end and output stage
	logic                         q_push;
	logic [ENTRY_W-1:0]           q_push_data;
	logic                         q_full;
	logic                         q_valid;
	logic                         q_pop;
	logic [ENTRY_W-1:0]           q_data;

	assign cfg_ready = 1'b1;

	// writes to an index past the register list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q    <= pdr_pkg::ROTATION_RST;
			source_size_q <= pdr_pkg::SOURCE_SIZE_RST;
			overlay_row_q <= pdr_pkg::OVERLAY_ROW_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (pdr_pkg::reg_idx_t'(cfg_index))
				pdr_pkg::REG_ROTATION:    rotation_q    <= pdr_pkg::rot_t'(cfg_data[1:0]);
				pdr_pkg::REG_SOURCE_SIZE: source_size_q <= cfg_data;
				pdr_pkg::REG_OVERLAY_ROW: overlay_row_q <= cfg_data[pdr_pkg::OVL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign back_cfg.rotation          = rotation_q;
	assign back_cfg.overlay_start_row = overlay_row_q;

	// every item waits while the queue is full, kept pixel or not
	assign in_ready = !q_full;

	// front end: classifies items and steps the accumulators
	pdr_front #(
		.DISPLAY_SIZE (DISPLAY_SIZE),
		.CW           (CW),
		.ENTRY_W      (ENTRY_W)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.operation      (operation),
		.pixel          (pixel),
		.overlay_active (overlay_active),
		.source_size    (source_size_q),
		.push_ready     (!q_full),
		.push           (q_push),
		.push_data      (q_push_data)
	);

	// kept pixels with their unrotated coordinates
	pdr_queue #(
		.DEPTH (QUEUE_DEPTH),
		.W     (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_data  (q_data)
	);

	// back end: rotation, overlay drop, byte swap and output register
	pdr_back #(
		.DISPLAY_SIZE (DISPLAY_SIZE),
		.CW           (CW),
		.ENTRY_W      (ENTRY_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (back_cfg),
		.entry_valid (q_valid),
		.entry       (q_data),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.dest_x      (dest_x),
		.dest_y      (dest_y),
		.color       (color)
	);

endmodule

>>> dv/pixel_downscale_rotate_writer_test.sv
`timescale 1ns / 100ps

module pixel_downscale_rotate_writer_test;
	import pdr_pkg::*;

	localparam int DISPLAY_SIZE  = DISPLAY_SIZE_DEF;
	// latency plus queue depth, with margin, for pixels dropped in the output stage
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int PHASES        = 8;
	// index with no register behind it, and the operation code with no meaning
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [1:0]           OP_SPARE  = 2'd3;

	// one display write as it leaves the block
	typedef struct packed {
		logic [DEST_W-1:0]  x;
		logic [DEST_W-1:0]  y;
		logic [PIXEL_W-1:0] color;
	} display_write_t;

	// mirrors the downscaler state and holds the display writes still owed
	class pixel_write_tracker;
		rot_t             rotation;
		logic [SRC_W-1:0] source_size;
		logic [OVL_W-1:0] overlay_row;
		bit               first_line_pending;
		logic [SRC_W-1:0] line_acc;
		logic [7:0]       row;
		bit               line_kept;
		logic [SRC_W-1:0] column_acc;
		logic [7:0]       column;
		display_write_t   pending_writes[$];
		int               mismatches;

		function new();
			rotation    = ROTATION_RST;
			source_size = SOURCE_SIZE_RST;
			overlay_row = OVERLAY_ROW_RST;
			mismatches  = 0;
			start_frame();
		endfunction

		function void start_frame();
			first_line_pending = 1'b1;
			line_acc           = '0;
			row                = '0;
			line_kept          = 1'b0;
			column_acc         = '0;
			column             = '0;
		endfunction

		// step by the display size, taking the source size off once on a wrap
		function bit step_wraps(inout logic [SRC_W-1:0] acc);
			logic [SRC_W:0] sum;
			bit             wrapped;
			sum     = {1'b0, acc} + (SRC_W+1)'(DISPLAY_SIZE);
			wrapped = sum >= {1'b0, source_size};
			if (wrapped)
				sum = sum - {1'b0, source_size};
			acc = sum[SRC_W-1:0];
			return wrapped;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_ROTATION:    rotation    = rot_t'(data[1:0]);
			REG_SOURCE_SIZE: source_size = data[SRC_W-1:0];
			REG_OVERLAY_ROW: overlay_row = data[OVL_W-1:0];
			default: ;
			endcase
		endfunction

		function void take_item(logic [1:0] op, logic [PIXEL_W-1:0] pix, logic ovl);
			logic [7:0]     last;
			logic [7:0]     x, y, dx, dy;
			display_write_t w;
			last = 8'(DISPLAY_SIZE - 1);
			case (op)
			OP_FRAME: start_frame();
			OP_LINE: begin
				column_acc = '0;
				column     = '0;
				if (first_line_pending) begin
					first_line_pending = 1'b0;
					line_acc           = '0;
					row                = '0;
					line_kept          = 1'b1;
				end else if (step_wraps(line_acc)) begin
					if (row < DISPLAY_SIZE)
						row++;
					line_kept = row < DISPLAY_SIZE;
				end else begin
					line_kept = 1'b0;
				end
			end
			OP_PIXEL: begin
				if (line_kept && column < DISPLAY_SIZE) begin
					if (step_wraps(column_acc)) begin
						x = column;
						y = row;
						column++;
						case (rotation)
						ROT_90: begin
							dx = last - y;
							dy = x;
						end
						ROT_180: begin
							dx = last - x;
							dy = last - y;
						end
						ROT_270: begin
							dx = y;
							dy = last - x;
						end
						default: begin
							dx = x;
							dy = y;
						end
						endcase
						if (!(ovl && dy >= overlay_row)) begin
							w.x     = dx[DEST_W-1:0];
							w.y     = dy[DEST_W-1:0];
							w.color = {pix[7:0], pix[15:8]};
							pending_writes.push_back(w);
						end
					end
				end
			end
			default: ;
			endcase
		endfunction

		function void check_write(logic [DEST_W-1:0] x, logic [DEST_W-1:0] y,
				logic [PIXEL_W-1:0] c);
			display_write_t want;
			if (pending_writes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected write: x=%0d y=%0d color=%h", x, y, c);
			end else begin
				want = pending_writes.pop_front();
				if (want.x !== x || want.y !== y || want.color !== c) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"write mismatch: expected x=%0d y=%0d color=%h,",
							" got x=%0d y=%0d color=%h"},
							want.x, want.y, want.color, x, y, c);
				end
			end
		endfunction
	endclass

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  in_valid       = 1'b0;
	logic                  in_ready;
	logic [1:0]            operation      = OP_FRAME;
	logic [PIXEL_W-1:0]    pixel          = '0;
	logic                  overlay_active = 1'b0;
	logic                  out_valid;
	logic                  out_ready      = 1'b0;
	logic [DEST_W-1:0]     dest_x;
	logic [DEST_W-1:0]     dest_y;
	logic [PIXEL_W-1:0]    color;
	logic                  cfg_valid      = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index      = REG_ROTATION;
	logic [CFG_DATA_W-1:0] cfg_data       = '0;

	pixel_write_tracker tracker = new();

	// percentages of cycles in which the camera side idles and the display side stalls
	int in_idle_pct   = 0;
	int out_stall_pct = 0;
	int items_sent    = 0;
	int cycle_count   = 0;

	pixel_downscale_rotate_writer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.pixel          (pixel),
		.overlay_active (overlay_active),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.dest_x         (dest_x),
		.dest_y         (dest_y),
		.color          (color),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case a transfer never completes
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// display side: check every write transfer, stall at random
	always @(posedge clk) begin
		if (out_valid && out_ready)
			tracker.check_write(dest_x, dest_y, color);
		out_ready <= $urandom_range(0, 99) >= out_stall_pct;
	end

	// one camera transfer; valid is left high so back-to-back items need no gap
	task automatic send_item(input logic [1:0] op, input logic [PIXEL_W-1:0] pix,
			input logic ovl);
		while (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		operation      <= op;
		pixel          <= pix;
		overlay_active <= ovl;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.take_item(op, pix, ovl);
		items_sent++;
	endtask

	// stray item: extra line start, lone pixel, unused code, now and then a frame restart
	task automatic send_noise();
		logic [1:0] op;
		op = ($urandom_range(0, 9) == 0) ? OP_FRAME : 2'($urandom_range(1, 3));
		send_item(op, 16'($urandom), 1'($urandom));
	endtask

	// register transfer; the caller drops valid after its last write
	task automatic post_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.write_register(idx, data);
	endtask

	// unused bits above the rotation and overlay-row fields carry noise, which the block must mask
	task automatic program_settings(input rot_t rot, input logic [SRC_W-1:0] src,
			input logic [OVL_W-1:0] first_row);
		post_register(REG_SPARE, 12'($urandom));
		post_register(REG_ROTATION, {10'($urandom), rot});
		post_register(REG_SOURCE_SIZE, src);
		post_register(REG_OVERLAY_ROW, {4'($urandom), first_row});
		cfg_valid <= 1'b0;
	endtask

	// wait for every owed write, then let dropped pixels clear the output queue
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending_writes.size() != 0)
			@(posedge clk);
		out_stall_pct = 0;
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// frames of short lines with random pixels; deep frames run past the last display row
	task automatic run_frames(input int budget, input bit deep_first);
		int target, lines, long_line, npix, l, k;
		bit deep;
		target = items_sent + budget;
		deep   = deep_first;
		while (items_sent < target) begin
			// now and then carry on in the frame already open
			if ($urandom_range(0, 9) != 0)
				send_item(OP_FRAME, 16'($urandom), 1'($urandom));
			lines     = deep ? $urandom_range(125, 135) : $urandom_range(1, 16);
			long_line = $urandom_range(0, lines - 1);
			for (l = 0; l < lines; l++) begin
				send_item(OP_LINE, 16'($urandom), 1'($urandom));
				// one long line runs past the last display column
				if (l == long_line && (deep || $urandom_range(0, 1) == 0))
					npix = $urandom_range(120, 140);
				else if (deep)
					npix = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
				else
					npix = $urandom_range(0, 6);
				for (k = 0; k < npix; k++) begin
					send_item(OP_PIXEL, 16'($urandom), 1'($urandom));
					if ($urandom_range(0, 29) == 0)
						send_noise();
				end
			end
			deep = $urandom_range(0, 3) == 0;
		end
	endtask

	initial begin
		int               p;
		rot_t             rot;
		logic [SRC_W-1:0] src;
		logic [OVL_W-1:0] first_row;

		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: pixel before any line is dropped, fourth pixel of the line is kept
		send_item(OP_FRAME, 16'h0000, 1'b0);
		send_item(OP_PIXEL, 16'hFFFF, 1'b0);
		send_item(OP_LINE, 16'h0000, 1'b0);
		send_item(OP_PIXEL, 16'h0000, 1'b0);
		send_item(OP_PIXEL, 16'h00FF, 1'b0);
		send_item(OP_PIXEL, 16'hFF00, 1'b0);
		send_item(OP_PIXEL, 16'hA55A, 1'b0);
		settle();

		// every pixel kept, overlay from row 0 so any overlay flag drops the write
		program_settings(ROT_270, 12'd128, 8'd0);
		send_item(OP_FRAME, 16'hFFFF, 1'b1);
		send_item(OP_LINE, 16'hFFFF, 1'b1);
		send_item(OP_PIXEL, 16'hFFFF, 1'b0);
		send_item(OP_PIXEL, 16'h0000, 1'b1);
		send_item(OP_SPARE, 16'hFFFF, 1'b1);
		send_item(OP_PIXEL, 16'h00FF, 1'b0);
		send_item(OP_LINE, 16'h0000, 1'b0);
		send_item(OP_PIXEL, 16'hFF00, 1'b1);
		send_item(OP_PIXEL, 16'h1234, 1'b0);
		settle();

		// random phases: each setting of rotation, source size and overlay row
		for (p = 0; p < PHASES; p++) begin
			rot = rot_t'(p % 4);
			case (p)
			0: src = 12'd128;
			1: src = 12'd4095;
			2: src = 12'd129;
			3: src = 12'($urandom_range(128, 300));
			4: src = SOURCE_SIZE_RST;
			// below the display size, down to zero
			5: src = ($urandom_range(0, 1) != 0) ? 12'd0 : 12'($urandom_range(1, 127));
			6: src = 12'd256;
			default: src = 12'($urandom_range(128, 4095));
			endcase
			if (p == 1)
				first_row = 8'd0;
			else if (p == 2)
				first_row = 8'd128;
			else if (p == 5)
				first_row = 8'($urandom_range(129, 255));
			else
				first_row = 8'($urandom_range(0, 127));
			program_settings(rot, src, first_row);

			case (p % 4)
			0: begin
				in_idle_pct   = 0;
				out_stall_pct = 0;
			end
			1: begin
				in_idle_pct   = 72;
				out_stall_pct = 0;
			end
			2: begin
				in_idle_pct   = 0;
				out_stall_pct = 72;
			end
			default: begin
				in_idle_pct   = 17;
				out_stall_pct = 17;
			end
			endcase
			run_frames(80, p == 0 || p == 3 || p == 5);
			in_idle_pct = 0;
			settle();
		end

		if (tracker.mismatches == 0 && tracker.pending_writes.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
